// File: hdl/mbhp_pkg.sv
package mbhp_pkg;

  // Parsing phase of the box stream.
  typedef enum logic [2:0] {
    PH_COMPACT  = 3'd0,
    PH_EXTENDED = 3'd1,
    PH_TYPE     = 3'd2,
    PH_DATA     = 3'd3,
    PH_ERROR    = 3'd4
  } phase_e;

  // Event code reported with every result item.
  typedef enum logic [2:0] {
    EV_HEADER  = 3'd0,
    EV_START   = 3'd1,
    EV_EMPTY   = 3'd2,
    EV_PAYLOAD = 3'd3,
    EV_LAST    = 3'd4,
    EV_ERROR   = 3'd5
  } event_e;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned TypeW     = 32;
  localparam int unsigned SizeW     = 64;
  localparam int unsigned CountW    = 4;

  // Field lengths in bytes.
  localparam logic [CountW-1:0] CompactLen  = 4'd4;
  localparam logic [CountW-1:0] ExtendedLen = 4'd8;
  localparam logic [CountW-1:0] TypeLen     = 4'd4;

  // Header lengths in bytes for the compact and the extended size form.
  localparam logic [SizeW-1:0] CompactHdr  = 64'd8;
  localparam logic [SizeW-1:0] ExtendedHdr = 64'd16;

  // Special size codes.
  localparam logic [31:0] SizeToEnd   = 32'd0;
  localparam logic [31:0] SizeExtends = 32'd1;

endpackage

// File: hdl/media_box_header_parser_unit.sv
// Box header parser for a byte stream of ISO base media boxes.
// Input channel: one stream byte per item on stream_byte_i, qualified by
// in_valid_i; the block drives in_stall_o. Output channel: one result item
// per input item (event code, box type, box size and payload byte),
// qualified by out_valid_o; the receiver drives out_stall_i. An item moves
// on an edge where valid is high and stall is low.
//
// The result of a byte is presented in the cycle after the byte is taken.
// Throughput is one byte per cycle unless the receiver stalls. The parser
// state is updated in the same cycle that a byte is taken, so the next
// byte can follow at once; the limit is the 64-bit payload countdown and
// its zero compare, which sit between the state registers.
//
// The output register holds a finished result until the receiver takes it.
// While it is full and the receiver stalls, in_stall_o is raised; a new
// byte is taken in the same cycle that the waiting result leaves.
//
// Reset clears the parser state: the parser waits for a compact size, the box
// type and size read zero, and no result is pending. An invalid size puts
// the parser in a sticky error phase that only reset leaves.
module media_box_header_parser_unit
  import mbhp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] stream_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       event_res_o,
  output logic [TypeW-1:0] box_type_o,
  output logic [SizeW-1:0] box_size_o,
  output logic [ByteW-1:0] payload_byte_o
);

  // Parser state.
  phase_e              phase_q, phase_d;
  logic [SizeW-1:0]    acc_q, acc_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [SizeW-1:0]    size_q, size_d;
  logic [SizeW-1:0]    left_q, left_d;
  logic [TypeW-1:0]    type_q, type_d;

  // Output register. Box type and size are taken straight from the state,
  // which only changes when a byte is taken and the output is reloaded.
  logic                out_valid_q, out_valid_d;
  event_e              event_q, event_d;
  logic [ByteW-1:0]    pay_q, pay_d;

  logic                in_fire;

  // Shared datapath terms.
  logic [SizeW-1:0]    acc_shift;
  logic [CountW-1:0]   cnt_inc;
  logic [31:0]         compact_v;
  logic [SizeW-1:0]    left_dec;
  logic                done4;
  logic                done8;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign acc_shift  = {acc_q[SizeW-ByteW-1:0], stream_byte_i};
  assign cnt_inc    = cnt_q + 4'd1;
  assign compact_v  = acc_shift[31:0];
  assign left_dec   = left_q - 64'd1;
  assign done4      = (cnt_inc >= CompactLen);
  assign done8      = (cnt_inc >= ExtendedLen);

  // Next state of the parser.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    size_d  = size_q;
    left_d  = left_q;
    type_d  = type_q;
    case (phase_q)
      PH_COMPACT: begin
        acc_d = acc_shift;
        cnt_d = cnt_inc;
        if (done4) begin
          acc_d = '0;
          cnt_d = '0;
          if (compact_v == SizeExtends) begin
            phase_d = PH_EXTENDED;
          end else if (compact_v == SizeToEnd) begin
            size_d  = '0;
            left_d  = '0;
            phase_d = PH_TYPE;
          end else if ({32'd0, compact_v} >= CompactHdr) begin
            size_d  = {32'd0, compact_v};
            left_d  = {32'd0, compact_v} - CompactHdr;
            phase_d = PH_TYPE;
          end else begin
            size_d  = {32'd0, compact_v};
            phase_d = PH_ERROR;
          end
        end
      end
      PH_EXTENDED: begin
        acc_d = acc_shift;
        cnt_d = cnt_inc;
        if (done8) begin
          acc_d  = '0;
          cnt_d  = '0;
          size_d = acc_shift;
          if (acc_shift == '0) begin
            left_d  = '0;
            phase_d = PH_TYPE;
          end else if (acc_shift >= ExtendedHdr) begin
            left_d  = acc_shift - ExtendedHdr;
            phase_d = PH_TYPE;
          end else begin
            phase_d = PH_ERROR;
          end
        end
      end
      PH_TYPE: begin
        acc_d = acc_shift;
        cnt_d = cnt_inc;
        if (done4) begin
          acc_d  = '0;
          cnt_d  = '0;
          type_d = acc_shift[TypeW-1:0];
          if (size_q == '0 || left_q != '0) begin
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_COMPACT;
          end
        end
      end
      PH_DATA: begin
        if (size_q != '0) begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_COMPACT;
          end
        end
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase
  end

  // Event code and payload byte for the byte being taken.
  always_comb begin
    event_d = EV_HEADER;
    pay_d   = '0;
    case (phase_q)
      PH_COMPACT: begin
        if (done4 && compact_v != SizeExtends && compact_v != SizeToEnd &&
            {32'd0, compact_v} < CompactHdr) begin
          event_d = EV_ERROR;
        end
      end
      PH_EXTENDED: begin
        if (done8 && acc_shift != '0 && acc_shift < ExtendedHdr) begin
          event_d = EV_ERROR;
        end
      end
      PH_TYPE: begin
        if (done4) begin
          event_d = (size_q == '0 || left_q != '0) ? EV_START : EV_EMPTY;
        end
      end
      PH_DATA: begin
        pay_d   = stream_byte_i;
        event_d = (size_q != '0 && left_dec == '0) ? EV_LAST : EV_PAYLOAD;
      end
      default: begin
        event_d = EV_ERROR;
      end
    endcase
  end

  // A result stays until taken; a new one enters whenever a byte is taken.
  assign out_valid_d = in_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COMPACT;
      acc_q       <= '0;
      cnt_q       <= '0;
      size_q      <= '0;
      left_q      <= '0;
      type_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        size_q  <= size_d;
        left_q  <= left_d;
        type_q  <= type_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      event_q <= event_d;
      pay_q   <= pay_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = event_q;
  assign box_type_o     = type_q;
  assign box_size_o     = size_q;
  assign payload_byte_o = pay_q;

  // The error phase is sticky.
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |=> phase_q == PH_ERROR)
    else $error("parser left the error phase");

  // A reported error always leaves the parser in the error phase.
  a_error_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && event_q == EV_ERROR |-> phase_q == PH_ERROR)
    else $error("error reported outside the error phase");

  // After the last payload byte the parser waits for the next size.
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && event_q == EV_LAST |-> phase_q == PH_COMPACT && left_q == '0)
    else $error("last payload byte without end of box");

  // A header field never holds more bytes than the extended size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < ExtendedLen)
    else $error("field byte count out of range");

  // A payload countdown only runs inside a sized box.
  a_left_sized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q != '0 |-> size_q != '0)
    else $error("payload count without a box size");

endmodule

// File: bench/media_box_header_parser_unit_tb.sv
`timescale 1ns / 1ps

module media_box_header_parser_unit_tb;
  import mbhp_pkg::*;

  // One result item of the parser, as the bench expects it.
  typedef struct packed {
    event_e           ev;
    logic [TypeW-1:0] box_type;
    logic [SizeW-1:0] box_size;
    logic [ByteW-1:0] payload;
  } box_event_t;

  // How the stream ends. Both a sticky error and a box that runs to the end
  // of the stream are states that only reset leaves, and reset is applied
  // once, so each run closes with one of them, picked at random.
  typedef enum int {
    TAIL_BAD_COMPACT,
    TAIL_BAD_EXTENDED,
    TAIL_OPEN_COMPACT,
    TAIL_OPEN_EXTENDED,
    TAIL_HUGE_EXTENDED,
    TAIL_HUGE_COMPACT
  } tail_e;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned CalmAfter  = 1450;
  localparam int unsigned HoldAfter  = 700;
  localparam int unsigned HoldCycles = 80;

  // Box parser scoreboard. It tracks the parse of the byte stream on its own
  // and keeps, in order, the events that the taken bytes should produce.
  class box_event_board;
    phase_e            phase;
    logic [SizeW-1:0]  field_bits;
    logic [CountW-1:0] field_count;
    logic [SizeW-1:0]  box_size;
    logic [SizeW-1:0]  bytes_left;
    logic [TypeW-1:0]  box_type;
    box_event_t        pending_events[$];
    int unsigned       errors;

    function new();
      phase       = PH_COMPACT;
      field_bits  = '0;
      field_count = '0;
      box_size    = '0;
      bytes_left  = '0;
      box_type    = '0;
      errors      = 0;
    endfunction

    // Shifts one byte into the field being collected. When the field is
    // complete its value is handed back and the collector starts over.
    function bit shift_field(logic [ByteW-1:0] b, logic [CountW-1:0] len,
                             output logic [SizeW-1:0] value);
      field_bits  = {field_bits[SizeW-9:0], b};
      field_count = field_count + 4'd1;
      value       = field_bits;
      if (field_count < len) begin
        return 1'b0;
      end
      field_bits  = '0;
      field_count = '0;
      return 1'b1;
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      box_event_t       e;
      logic [SizeW-1:0] v;
      e.ev      = EV_HEADER;
      e.payload = '0;
      case (phase)
        PH_COMPACT: begin
          if (shift_field(b, CompactLen, v)) begin
            v = {32'd0, v[31:0]};
            if (v == 64'(SizeExtends)) begin
              phase = PH_EXTENDED;
            end else if (v == 64'(SizeToEnd)) begin
              box_size   = '0;
              bytes_left = '0;
              phase      = PH_TYPE;
            end else if (v >= CompactHdr) begin
              box_size   = v;
              bytes_left = v - CompactHdr;
              phase      = PH_TYPE;
            end else begin
              box_size = v;
              phase    = PH_ERROR;
              e.ev     = EV_ERROR;
            end
          end
        end
        PH_EXTENDED: begin
          if (shift_field(b, ExtendedLen, v)) begin
            box_size = v;
            if (v == '0) begin
              bytes_left = '0;
              phase      = PH_TYPE;
            end else if (v >= ExtendedHdr) begin
              bytes_left = v - ExtendedHdr;
              phase      = PH_TYPE;
            end else begin
              phase = PH_ERROR;
              e.ev  = EV_ERROR;
            end
          end
        end
        PH_TYPE: begin
          if (shift_field(b, TypeLen, v)) begin
            box_type = v[TypeW-1:0];
            if (box_size == '0 || bytes_left != '0) begin
              phase = PH_DATA;
              e.ev  = EV_START;
            end else begin
              phase = PH_COMPACT;
              e.ev  = EV_EMPTY;
            end
          end
        end
        PH_DATA: begin
          e.payload = b;
          e.ev      = EV_PAYLOAD;
          // A box of size zero never counts down and never ends.
          if (box_size != '0) begin
            bytes_left = bytes_left - 64'd1;
            if (bytes_left == '0) begin
              e.ev  = EV_LAST;
              phase = PH_COMPACT;
            end
          end
        end
        default: begin
          phase = PH_ERROR;
          e.ev  = EV_ERROR;
        end
      endcase
      e.box_type = box_type;
      e.box_size = box_size;
      pending_events.push_back(e);
    endfunction

    function void check_result(logic [2:0] ev, logic [TypeW-1:0] typ,
                               logic [SizeW-1:0] size, logic [ByteW-1:0] pay);
      box_event_t want;
      box_event_t got;
      got = '{event_e'(ev), typ, size, pay};
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: result with no byte waiting: ev %0d type %h size %h byte %h",
                 $time, ev, typ, size, pay);
        return;
      end
      want = pending_events.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: expected ev %0d type %h size %h byte %h",
                 $time, want.ev, want.box_type, want.box_size, want.payload);
        $display("%0t:   actual ev %0d type %h size %h byte %h",
                 $time, got.ev, got.box_type, got.box_size, got.payload);
      end
    endfunction

    function int unsigned waiting();
      return pending_events.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] stream_byte_i = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [2:0]       event_res_o;
  logic [TypeW-1:0] box_type_o;
  logic [SizeW-1:0] box_size_o;
  logic [ByteW-1:0] payload_byte_o;

  box_event_board board;
  int unsigned    bytes_taken = 0;
  int unsigned    gap_pct     = 0;
  int unsigned    cycle_count = 0;
  bit             calm        = 1'b0;

  media_box_header_parser_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .box_type_o     (box_type_o),
    .box_size_o     (box_size_o),
    .payload_byte_o (payload_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Both channels are sampled at the rising edge. All inputs change by
  // nonblocking assignment at that same edge, so the values read here are
  // the ones that stood before it, and an item moves when valid was high
  // and stall was low. The byte is noted before the result is checked so
  // that the order holds even if a result could follow its byte at once.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_byte(stream_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_result(event_res_o, box_type_o, box_size_o, payload_byte_o);
      end
    end
  end

  // Guard against a hung handshake. The slowest correct run is far below
  // this limit even with every idle burst at its longest.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("media_box_header_parser_unit verification failed");
      $finish;
    end
  end

  // Offers one byte and holds it until the parser takes it. An idle burst
  // may come first; valid is then lowered at one edge and raised again at
  // a later one, never both within one time step.
  task automatic put_byte(input logic [ByteW-1:0] b);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_taken++;
  endtask

  // Sends the low n bytes of a value, most significant byte first.
  task automatic put_word(input logic [SizeW-1:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      put_byte(v[8*i +: 8]);
    end
  endtask

  // Sends one well-formed box with a random type and random payload bytes,
  // in the compact or the extended size form.
  task automatic put_box(input bit extended, input int unsigned len);
    if (extended) begin
      put_word(64'(SizeExtends), 4);
      put_word(64'(len) + ExtendedHdr, 8);
    end else begin
      put_word(64'(len) + CompactHdr, 4);
    end
    put_word(64'($urandom), 4);
    repeat (len) put_byte(8'($urandom_range(0, 255)));
  endtask

  // Receiver side. Stalls come in short bursts whose rate is picked anew at
  // random, with stretches that have none at all. Once, well into the
  // run, the receiver holds off for a long stretch while the sender keeps
  // offering bytes, so the output register fills and the parser has to
  // stall its input. Near the end the receiver takes everything at once.
  initial begin : receiver
    int unsigned stall_pct;
    int unsigned ticks;
    bit          held_off;
    stall_pct = 0;
    ticks     = 0;
    held_off  = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      ticks++;
      if (ticks % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 12;
          default: stall_pct = 35;
        endcase
      end
      if (!held_off && bytes_taken >= HoldAfter) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned pick;
    tail_e       tail;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A compact box of size ten with an all-ones type and
    // the payload bytes zero and all-ones, the second one being the last.
    // Then an extended box of exactly header length, which is empty, with
    // an all-zero type.
    put_word(64'd10, 4);
    put_word(64'hFFFF_FFFF, 4);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_word(64'(SizeExtends), 4);
    put_word(ExtendedHdr, 8);
    put_word(64'd0, 4);

    // Random part: a stream of well-formed boxes. Most payloads are short,
    // a fifth are empty, and a tenth are 25 to 300 bytes long so that the
    // upper size bytes move too. The sender's idle rate changes per box.
    while (bytes_taken < 1600) begin
      calm = (bytes_taken >= CalmAfter);
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 0;
        2:       gap_pct = 20;
        default: gap_pct = 45;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        len = 0;
      end else if (pick < 90) begin
        len = $urandom_range(1, 24);
      end else begin
        len = $urandom_range(25, 300);
      end
      put_box($urandom_range(0, 3) == 0, len);
    end

    // The stream ends in a state that only reset would leave: a size below
    // the header length followed by bytes that must all answer as errors,
    // a box of size zero in either form that runs to the end, or a box so
    // large that it cannot end within the run.
    calm = 1'b1;
    tail = tail_e'($urandom_range(0, 5));
    case (tail)
      TAIL_BAD_COMPACT: begin
        put_word(64'($urandom_range(2, 7)), 4);
      end
      TAIL_BAD_EXTENDED: begin
        put_word(64'(SizeExtends), 4);
        put_word(64'($urandom_range(1, 15)), 8);
      end
      TAIL_OPEN_COMPACT: begin
        put_word(64'(SizeToEnd), 4);
        put_word(64'($urandom), 4);
      end
      TAIL_OPEN_EXTENDED: begin
        put_word(64'(SizeExtends), 4);
        put_word(64'd0, 8);
        put_word(64'($urandom), 4);
      end
      TAIL_HUGE_EXTENDED: begin
        put_word(64'(SizeExtends), 4);
        put_word({1'b1, 31'($urandom), 32'($urandom)}, 8);
        put_word(64'($urandom), 4);
      end
      default: begin
        put_word(64'(32'h8000_0000 | $urandom), 4);
        put_word(64'($urandom), 4);
      end
    endcase
    repeat (30) put_byte(8'($urandom_range(0, 255)));
    in_valid_i <= 1'b0;

    // Drain: every taken byte must have produced its result, then a few
    // more cycles catch any result that should not be there at all.
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("media_box_header_parser_unit verification clean");
    end else begin
      $display("media_box_header_parser_unit verification failed");
    end
    $finish;
  end

endmodule
